>>> rtl/core/chunked_fixed_block_allocator_top_assert.svh
// Assertion macros for the chunk allocator
`ifndef CHUNKED_FIXED_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define CHUNKED_FIXED_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
// a implies b at the same edge
`define CFBA_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("%m: check failed");
// a implies b at the next edge
`define CFBA_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("%m: check failed");
`endif

>>> rtl/core/cfba_pkg.sv
// Types and constants shared by the chunk allocator
package cfba_pkg;
    localparam int MAX_CHUNKS = 8;
    localparam int BLOCK_LIMIT = 255;
    localparam int SLOT_W = $clog2(MAX_CHUNKS);
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int LINK_DEPTH = 2048;
    localparam int LINK_AW = 11;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic MODE_ALLOC = 1'b0;

    typedef struct packed {
        logic       mode;
        logic [2:0] region;
        logic [7:0] block_index;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] out_region;
        logic [7:0] out_block;
    } rsp_t;
endpackage

>>> rtl/core/cfba_ram.sv
// Generic single-port-write, single-read RAM with registered read
module cfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/chunked_fixed_block_allocator_top.sv
// Top level of the chunk allocator: sequencer, slot table and link memory
//
// channel | dir | handshake         | payload
// in      | in  | in_valid/in_stall | req_t  (mode, region, block_index)
// out     | out | out_valid/out_stall | rsp_t (status, out_region, out_block)
//
// An allocate from the cached chunk goes through S_READ, S_POP and S_DONE before out_valid
// rises; when the cursor is stale it first scans the slots in S_SCAN, one slot per cycle.
// Opening a new chunk first writes its links in S_INIT, one block per cycle;
// a full table answers via S_DONE after the scan. A free goes through S_FREE and S_DONE.
// Reset clears the slot counts, first blocks and counters; slot regions and the link memory are not cleared.
// A result waits in the output register; the next request is taken after it is accepted.
module chunked_fixed_block_allocator_top
    import cfba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  req_t       in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output rsp_t       out_data,
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic       paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);
`include "chunked_fixed_block_allocator_top_assert.svh"

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_INIT, S_READ, S_POP, S_FREE, S_DONE} state_t;

    state_t state_reg;
    logic [7:0] bpc_reg;
    req_t req_reg;
    rsp_t rsp_reg;
    logic out_valid_reg;
    logic [7:0] first_reg [MAX_CHUNKS];
    logic [7:0] cnt_reg [MAX_CHUNKS];
    logic [2:0] reg_reg [MAX_CHUNKS];
    logic [CNT_W-1:0] chunk_count_reg;
    logic [SLOT_W-1:0] acur_reg;
    logic acur_valid_reg;
    logic [SLOT_W-1:0] dcur_reg;
    logic [7:0] in_use_reg;
    logic [SLOT_W-1:0] scan_reg;
    logic [7:0] idx_reg;
    logic [2:0] nreg_reg;

    logic [7:0] n_eff;
    assign n_eff = (bpc_reg == 8'd0) ? 8'd1
                 : (bpc_reg > 8'(BLOCK_LIMIT)) ? 8'(BLOCK_LIMIT) : bpc_reg;

    logic ram_we;
    logic [LINK_AW-1:0] ram_wa, ram_ra;
    logic [7:0] ram_wd, ram_rd;

    cfba_ram #(.WIDTH(8), .DEPTH(LINK_DEPTH)) u_link (
        .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
        .raddr(ram_ra), .rdata(ram_rd)
    );

    assign pready = 1'b1;
    assign prdata = {24'd0, bpc_reg};
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data = rsp_reg;

    logic [SLOT_W-1:0] as;
    assign as = acur_reg;
    assign ram_ra = {reg_reg[as], first_reg[as]};

    // free region lookup: first live slot with matching region
    logic found;
    logic [SLOT_W-1:0] fslot;
    always_comb
    begin
        found = 1'b0;
        fslot = '0;
        for (int i = MAX_CHUNKS - 1; i >= 0; i--)
        begin
            if (CNT_W'(i) < chunk_count_reg && reg_reg[i] == req_reg.region)
            begin
                found = 1'b1;
                fslot = SLOT_W'(i);
            end
        end
    end

    logic have_r;
    logic [2:0] low_r;
    always_comb
    begin
        have_r = 1'b0;
        low_r = '0;
        for (int r = 7; r >= 0; r--)
        begin
            if (!in_use_reg[r])
            begin
                have_r = 1'b1;
                low_r = 3'(r);
            end
        end
    end

    logic [SLOT_W-1:0] last;
    assign last = SLOT_W'(chunk_count_reg - CNT_W'(1));
    logic [7:0] cnt_inc;
    assign cnt_inc = (cnt_reg[fslot] == 8'hFF) ? 8'hFF : cnt_reg[fslot] + 8'd1;

    always_comb
    begin
        ram_we = 1'b0;
        ram_wa = '0;
        ram_wd = '0;
        if (state_reg == S_INIT)
        begin
            ram_we = 1'b1;
            ram_wa = {nreg_reg, idx_reg};
            ram_wd = idx_reg + 8'd1;
        end
        else if (state_reg == S_FREE && found && req_reg.block_index < n_eff)
        begin
            ram_we = 1'b1;
            ram_wa = {req_reg.region, req_reg.block_index};
            ram_wd = first_reg[fslot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bpc_reg <= 8'd255;
            out_valid_reg <= 1'b0;
            chunk_count_reg <= '0;
            acur_reg <= '0;
            acur_valid_reg <= 1'b0;
            dcur_reg <= '0;
            in_use_reg <= '0;
            scan_reg <= '0;
            idx_reg <= '0;
            nreg_reg <= '0;
            for (int i = 0; i < MAX_CHUNKS; i++)
            begin
                first_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (psel && penable && pwrite && paddr == 1'b0)
            begin
                bpc_reg <= pwdata[7:0];
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        req_reg <= in_data;
                        scan_reg <= '0;
                        if (in_data.mode == MODE_ALLOC)
                        begin
                            if (acur_valid_reg && CNT_W'(acur_reg) < chunk_count_reg
                                && cnt_reg[acur_reg] != 8'd0)
                            begin
                                state_reg <= S_READ;
                            end
                            else
                            begin
                                state_reg <= S_SCAN;
                            end
                        end
                        else
                        begin
                            state_reg <= S_FREE;
                        end
                    end
                end
                S_SCAN:
                begin
                    // walk one slot per cycle
                    if (CNT_W'(scan_reg) < chunk_count_reg && cnt_reg[scan_reg] != 8'd0)
                    begin
                        acur_reg <= scan_reg;
                        acur_valid_reg <= 1'b1;
                        state_reg <= S_READ;
                    end
                    else if (CNT_W'(scan_reg) + CNT_W'(1) < chunk_count_reg)
                    begin
                        scan_reg <= scan_reg + SLOT_W'(1);
                    end
                    else if (chunk_count_reg >= CNT_W'(MAX_CHUNKS) || !have_r)
                    begin
                        rsp_reg <= '{status: ST_FULL, out_region: '0, out_block: '0};
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        nreg_reg <= low_r;
                        idx_reg <= '0;
                        state_reg <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    if (idx_reg + 8'd1 >= n_eff)
                    begin
                        reg_reg[SLOT_W'(chunk_count_reg)] <= nreg_reg;
                        first_reg[SLOT_W'(chunk_count_reg)] <= '0;
                        cnt_reg[SLOT_W'(chunk_count_reg)] <= n_eff;
                        in_use_reg[nreg_reg] <= 1'b1;
                        acur_reg <= SLOT_W'(chunk_count_reg);
                        acur_valid_reg <= 1'b1;
                        chunk_count_reg <= chunk_count_reg + CNT_W'(1);
                        dcur_reg <= '0;
                        state_reg <= S_READ;
                    end
                    idx_reg <= idx_reg + 8'd1;
                end
                S_READ:
                begin
                    state_reg <= S_POP;
                end
                S_POP:
                begin
                    first_reg[as] <= ram_rd;
                    cnt_reg[as] <= cnt_reg[as] - 8'd1;
                    rsp_reg <= '{status: ST_OK, out_region: reg_reg[as],
                                 out_block: first_reg[as]};
                    state_reg <= S_DONE;
                end
                S_FREE:
                begin
                    state_reg <= S_DONE;
                    if (!found || req_reg.block_index >= n_eff)
                    begin
                        rsp_reg <= '{status: ST_UNKNOWN, out_region: '0, out_block: '0};
                    end
                    else
                    begin
                        rsp_reg <= '{status: ST_OK, out_region: '0, out_block: '0};
                        dcur_reg <= fslot;
                        first_reg[fslot] <= req_reg.block_index;
                        cnt_reg[fslot] <= cnt_inc;
                        if (cnt_inc == n_eff)
                        begin
                            if (fslot == last)
                            begin
                                if (chunk_count_reg > CNT_W'(1)
                                    && cnt_reg[fslot - SLOT_W'(1)] == n_eff)
                                begin
                                    in_use_reg[reg_reg[last]] <= 1'b0;
                                    chunk_count_reg <= chunk_count_reg - CNT_W'(1);
                                    acur_reg <= '0;
                                    acur_valid_reg <= 1'b1;
                                    dcur_reg <= '0;
                                end
                            end
                            else if (cnt_reg[last] == n_eff)
                            begin
                                in_use_reg[reg_reg[last]] <= 1'b0;
                                chunk_count_reg <= chunk_count_reg - CNT_W'(1);
                                acur_reg <= fslot;
                                acur_valid_reg <= 1'b1;
                            end
                            else
                            begin
                                // swap freed slot with the last one
                                reg_reg[fslot] <= reg_reg[last];
                                reg_reg[last] <= reg_reg[fslot];
                                first_reg[fslot] <= first_reg[last];
                                first_reg[last] <= req_reg.block_index;
                                cnt_reg[fslot] <= cnt_reg[last];
                                cnt_reg[last] <= cnt_inc;
                                acur_reg <= last;
                                acur_valid_reg <= 1'b1;
                            end
                        end
                    end
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `CFBA_ASSERT_IMP(a_count_range, 1'b1, chunk_count_reg <= CNT_W'(MAX_CHUNKS))
    `CFBA_ASSERT_IMP(a_stall_busy, state_reg != S_IDLE, in_stall)
    `CFBA_ASSERT_NXT(a_done_valid, state_reg == S_DONE, out_valid_reg)
    `CFBA_ASSERT_IMP(a_uses_regions, 1'b1,
                     CNT_W'($countones(in_use_reg)) == chunk_count_reg)
    `CFBA_ASSERT_IMP(a_dcur_live, chunk_count_reg != '0, CNT_W'(dcur_reg) < chunk_count_reg)
endmodule
